// File: hdl/fbfa_pkg.sv
// Package for the first/best-fit block allocator.
// Word types, mode codes, register address, default sizes and the cell control struct.
// No dependencies.
package fbfa_pkg;

  localparam int NumEntriesDef = 16;
  localparam int SizeBitsDef   = 16;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeFirst = 2'd1;
  localparam logic [1:0] ModeBest  = 2'd2;

  localparam logic [1:0] RegBlockCount = 2'd0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  entry_index;
    logic [15:0] load_size;
    logic [15:0] min_size;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  chosen_index;
    logic [15:0] chosen_size;
  } out_word_t;

  typedef struct packed {
    logic best_mode;
    logic commit;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StSearch = 2'b10
  } state_e;

endpackage

// File: hdl/fbfa_cell.sv
// One table entry of the allocator: stored size and taken flag.
// Compares itself against the request and passes the running pick on.
// Depends on fbfa_pkg.
module fbfa_cell #(
  parameter int NumEntries = fbfa_pkg::NumEntriesDef,
  parameter int SizeBits   = fbfa_pkg::SizeBitsDef,
  parameter int Index      = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbfa_pkg::cell_ctrl_t          ctrl_i,
  input  logic                          active_i,
  input  logic                          load_i,
  input  logic [SizeBits-1:0]           load_size_i,
  input  logic [15:0]                   req_i,
  input  logic [$clog2(NumEntries)-1:0] pick_i,
  input  logic                          hit_i,
  input  logic [$clog2(NumEntries)-1:0] idx_i,
  input  logic [SizeBits-1:0]           size_i,
  output logic                          hit_o,
  output logic [$clog2(NumEntries)-1:0] idx_o,
  output logic [SizeBits-1:0]           size_o
);
  import fbfa_pkg::*;

  localparam int IdxW = $clog2(NumEntries);
  localparam int CmpW = (SizeBits > 16) ? SizeBits : 16;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic [SizeBits-1:0] size_q;
  logic                taken_q;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [SizeBits-1:0] cand_size_q, cand_size_d;
  logic                fits, take;

  assign fits = active_i && !taken_q && (CmpW'(size_q) >= CmpW'(req_i));
  assign take = fits && (!hit_i || (ctrl_i.best_mode && (size_q < size_i)));

  always_comb begin
    if (take) begin
      hit_d       = 1'b1;
      idx_d       = MyIdx;
      cand_size_d = size_q;
    end else begin
      hit_d       = hit_i;
      idx_d       = idx_i;
      cand_size_d = size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      size_q <= load_size_i;
    end
    idx_q       <= idx_d;
    cand_size_q <= cand_size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      hit_q <= hit_d;
      if (load_i) begin
        taken_q <= 1'b0;
      end else if (ctrl_i.commit && (pick_i == MyIdx)) begin
        taken_q <= 1'b1;
      end
    end
  end

  assign hit_o  = hit_q;
  assign idx_o  = idx_q;
  assign size_o = cand_size_q;

endmodule

// File: hdl/first_best_fit_block_allocator_core.sv
// Top level of the first/best-fit block allocator: APB register, control,
// and the chain of fbfa_cell entries. Depends on fbfa_pkg and fbfa_cell.
//
// Channel  | Handshake             | Word
// input    | start_i, busy_o       | in_i  (fbfa_pkg::in_word_t)
// result   | done_o (1-cycle)      | out_o (fbfa_pkg::out_word_t)
// config   | psel/penable/pwrite   | pwdata[4:0] -> block_count, any address
//
// A load writes its cell and busy_o stays low. A request keeps busy_o high
// while the pick ripples one cell per cycle down the chain; the result word
// shows in the same cycle that busy_o falls.
// Reset clears all taken flags and block_count; sizes are unknown until loaded.
// The receiver cannot stall the result.
module first_best_fit_block_allocator_core #(
  parameter int NumEntries = fbfa_pkg::NumEntriesDef,
  parameter int SizeBits   = fbfa_pkg::SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  fbfa_pkg::in_word_t  in_i,
  output logic                done_o,
  output fbfa_pkg::out_word_t out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fbfa_pkg::*;

  localparam int IdxW = $clog2(NumEntries);
  localparam int CntW = $clog2(NumEntries + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [4:0]          count_q;
  logic [15:0]         req_q;
  logic                best_q;
  logic                done_q;
  out_word_t           out_q;
  logic                accept, is_req, finish;
  cell_ctrl_t          ctrl;
  logic [SizeBits-1:0] load_size;

  logic                hit_c  [NumEntries+1];
  logic [IdxW-1:0]     idx_c  [NumEntries+1];
  logic [SizeBits-1:0] size_c [NumEntries+1];

  assign pready = 1'b1;
  assign prdata = (paddr == RegBlockCount) ? {27'd0, count_q} : 32'd0;

  assign accept    = start_i && (state_q == StIdle);
  assign is_req    = (in_i.mode == ModeFirst) || (in_i.mode == ModeBest);
  assign finish    = (state_q == StSearch) && (cnt_q == CntW'(NumEntries));
  assign load_size = SizeBits'(in_i.load_size);

  assign ctrl.best_mode = best_q;
  assign ctrl.commit    = finish && hit_c[NumEntries];

  assign hit_c[0]  = 1'b0;
  assign idx_c[0]  = '0;
  assign size_c[0] = '0;

  for (genvar g = 0; g < NumEntries; g++) begin : g_cell
    logic active, load;
    assign active = 32'(count_q) > 32'(g);
    assign load   = accept && (in_i.mode == ModeLoad) && (32'(in_i.entry_index) == 32'(g));

    fbfa_cell #(
      .NumEntries (NumEntries),
      .SizeBits   (SizeBits),
      .Index      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .active_i    (active),
      .load_i      (load),
      .load_size_i (load_size),
      .req_i       (req_q),
      .pick_i      (idx_c[NumEntries]),
      .hit_i       (hit_c[g]),
      .idx_i       (idx_c[g]),
      .size_i      (size_c[g]),
      .hit_o       (hit_c[g+1]),
      .idx_o       (idx_c[g+1]),
      .size_o      (size_c[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept && is_req) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        cnt_d = cnt_q + CntW'(1);
        if (finish) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= finish;
      if (psel && penable && pwrite && pready) begin
        count_q <= pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_i.min_size;
      best_q <= (in_i.mode == ModeBest);
    end
    if (finish) begin
      out_q.found        <= hit_c[NumEntries];
      out_q.chosen_index <= hit_c[NumEntries] ? 4'(idx_c[NumEntries]) : 4'd0;
      out_q.chosen_size  <= hit_c[NumEntries] ? 16'(size_c[NumEntries]) : 16'd0;
    end
  end

  assign busy_o = (state_q == StSearch);
  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

// File: hdl/fbfa_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on fbfa_pkg and first_best_fit_block_allocator_core.
module fbfa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input fbfa_pkg::in_word_t  in_i,
  input logic                done_o,
  input fbfa_pkg::out_word_t out_o
);
  import fbfa_pkg::*;

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.mode == ModeFirst || in_i.mode == ModeBest)) |=> busy_o)
    else $error("request word did not start a search");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("search ended without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while busy");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back results");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_o.found) |-> (out_o.chosen_index == 4'd0 && out_o.chosen_size == 16'd0))
    else $error("miss result not zeroed");

endmodule

bind first_best_fit_block_allocator_core fbfa_checker u_fbfa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .in_i    (in_i),
  .done_o  (done_o),
  .out_o   (out_o)
);
